// File: sv/sky_env_pkg.sv
`default_nettype none

package sky_env_pkg;

  // Item operation codes
  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_FETCH = 1'b1
  } op_e;

  // Fixed widths of the item and result fields
  localparam int LEFT_W   = 14;
  localparam int RIGHT_W  = 15;
  localparam int HEIGHT_W = 16;
  localparam int POINT_W  = 15;

endpackage

`default_nettype wire

// File: sv/sky_env_ram.sv
`default_nettype none

module sky_env_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/skyline_envelope.sv
// Channel   Handshake               Fields
// ------    ---------               ------
// item in   start_i high, busy_o low  op_i, left_edge_i, bldg_height_i, right_edge_i
// result    res_valid_o, one cycle  point_x_o, point_height_o, done_res_o
//
// Add: one cell per cycle through the height RAM
// (read one cell while writing back the previous). An empty building is dropped.
// Fetch: walks the cells from the scan pointer and clears each one it reads.
// After reset the RAM is zeroed with busy_o high.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module skyline_envelope
  import sky_env_pkg::*;
#(
  parameter int COORD_SPAN  = 16384,
  parameter int HEIGHT_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic                op_i,
  input  wire logic [LEFT_W-1:0]   left_edge_i,
  input  wire logic [HEIGHT_W-1:0] bldg_height_i,
  input  wire logic [RIGHT_W-1:0]  right_edge_i,
  output logic                     res_valid_o,
  output logic [POINT_W-1:0]       point_x_o,
  output logic [HEIGHT_W-1:0]      point_height_o,
  output logic                     done_res_o
);

  localparam int AW  = $clog2(COORD_SPAN);
  localparam int PW  = $clog2(COORD_SPAN + 1);
  localparam int HW  = HEIGHT_BITS;
  localparam int CW  = (PW > RIGHT_W) ? PW : RIGHT_W;
  localparam int XPW = (PW > POINT_W) ? PW : POINT_W;
  localparam int XW  = (HW > HEIGHT_W) ? HW : HEIGHT_W;

  localparam logic [PW-1:0]  SPAN_P  = PW'(COORD_SPAN);
  localparam logic [CW-1:0]  SPAN_C  = CW'(COORD_SPAN);
  localparam logic [AW-1:0]  LAST_A  = AW'(COORD_SPAN - 1);
  localparam logic [XPW-1:0] SPAN_X  = XPW'(COORD_SPAN);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD,
    S_ADD_DRAIN,
    S_FETCH
  } state_e;

  state_e            state_q;
  logic [PW-1:0]     ptr_q;
  logic [PW-1:0]     end_q;
  logic [PW-1:0]     scan_ptr_q;
  logic [HW-1:0]     prev_q;
  logic [HW-1:0]     h_q;
  logic              p1_vld_q;
  logic [AW-1:0]     p1_addr_q;
  logic              res_valid_q;
  logic [POINT_W-1:0] out_x_q;
  logic [HEIGHT_W-1:0] out_h_q;
  logic              out_done_q;

  // RAM side
  logic              we;
  logic [AW-1:0]     waddr;
  logic [HW-1:0]     wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [HW-1:0]     rdata;

  // Decoded item fields
  logic [CW-1:0]     left_c, right_c, lo_c, hi_c;
  logic [PW-1:0]     lo, hi;
  logic [XW-1:0]     h_ext;
  logic [HW-1:0]     h_in;
  logic [XW-1:0]     rdata_x;
  logic [XPW-1:0]    p1_addr_x;
  logic              hit, last_cell;

  always_comb begin
    left_c  = CW'(left_edge_i);
    right_c = CW'(right_edge_i);
    lo_c    = (left_c > SPAN_C) ? SPAN_C : left_c;
    hi_c    = (right_c > SPAN_C) ? SPAN_C : right_c;
    lo      = lo_c[PW-1:0];
    hi      = hi_c[PW-1:0];
    h_ext   = XW'(bldg_height_i);
    h_in    = h_ext[HW-1:0];
    rdata_x   = XW'(rdata);
    p1_addr_x = XPW'(p1_addr_q);
  end

  always_comb begin
    hit       = p1_vld_q && (state_q == S_FETCH) && (rdata != prev_q);
    last_cell = p1_vld_q && (p1_addr_q == LAST_A);

    // Speculative read of the next cell; drop it once the scan stops
    re    = (state_q == S_ADD) ||
            ((state_q == S_FETCH) && !hit && (ptr_q < SPAN_P));
    raddr = ptr_q[AW-1:0];

    we    = 1'b0;
    waddr = p1_addr_q;
    wdata = '0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = ptr_q[AW-1:0];
      end
      S_FETCH: begin
        // Every cell the scan reads is cleared
        we = p1_vld_q;
      end
      S_ADD, S_ADD_DRAIN: begin
        we    = p1_vld_q && (rdata < h_q);
        wdata = h_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  sky_env_ram #(
    .WIDTH (HW),
    .DEPTH (COORD_SPAN)
  ) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ptr_q       <= '0;
      end_q       <= '0;
      scan_ptr_q  <= '0;
      prev_q      <= '0;
      h_q         <= '0;
      p1_vld_q    <= 1'b0;
      p1_addr_q   <= '0;
      res_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_h_q     <= '0;
      out_done_q  <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      p1_vld_q    <= re;
      p1_addr_q   <= raddr;
      case (state_q)
        S_CLEAR: begin
          ptr_q <= ptr_q + PW'(1);
          if (ptr_q[AW-1:0] == LAST_A) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            if (op_e'(op_i) == OP_ADD) begin
              if (lo < hi) begin
                ptr_q   <= lo;
                end_q   <= hi;
                h_q     <= h_in;
                state_q <= S_ADD;
              end
            end else if (scan_ptr_q < SPAN_P) begin
              ptr_q   <= scan_ptr_q;
              state_q <= S_FETCH;
            end else begin
              // Pointer at end of span: close the skyline or give done
              res_valid_q <= 1'b1;
              out_h_q     <= '0;
              if (prev_q != '0) begin
                out_x_q    <= SPAN_X[POINT_W-1:0];
                out_done_q <= 1'b0;
                prev_q     <= '0;
              end else begin
                out_x_q    <= '0;
                out_done_q <= 1'b1;
                scan_ptr_q <= '0;
              end
            end
          end
        end
        S_ADD: begin
          ptr_q <= ptr_q + PW'(1);
          if (ptr_q == end_q - PW'(1)) begin
            state_q <= S_ADD_DRAIN;
          end
        end
        S_ADD_DRAIN: begin
          // Let the last write-back land
          state_q <= S_IDLE;
        end
        S_FETCH: begin
          if (re) begin
            ptr_q <= ptr_q + PW'(1);
          end
          if (hit) begin
            res_valid_q <= 1'b1;
            out_x_q     <= p1_addr_x[POINT_W-1:0];
            out_h_q     <= rdata_x[HEIGHT_W-1:0];
            out_done_q  <= 1'b0;
            prev_q      <= rdata;
            scan_ptr_q  <= PW'(p1_addr_q) + PW'(1);
            state_q     <= S_IDLE;
          end else if (last_cell) begin
            res_valid_q <= 1'b1;
            out_h_q     <= '0;
            state_q     <= S_IDLE;
            if (prev_q != '0) begin
              out_x_q    <= SPAN_X[POINT_W-1:0];
              out_done_q <= 1'b0;
              prev_q     <= '0;
              scan_ptr_q <= SPAN_P;
            end else begin
              out_x_q    <= '0;
              out_done_q <= 1'b1;
              scan_ptr_q <= '0;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign res_valid_o    = res_valid_q;
  assign point_x_o      = out_x_q;
  assign point_height_o = out_h_q;
  assign done_res_o     = out_done_q;

endmodule

`default_nettype wire
